// ===== rtl/core/q2e_pkg.sv =====
// q2e_pkg: shared widths, fixed-point constants and helpers for the quaternion to euler block
// no dependencies; used by q2e_isqrt, q2e_cordic, quaternion_to_euler_unit and q2e_checker
`default_nettype none

package q2e_pkg;

    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int COMPONENT_BITS_DEF = 16;

    // working widths
    localparam int QW      = 16;           // normalized component, q1.15
    localparam int PROD_W  = 2 * QW;       // one product, q.30
    localparam int TERM_W  = PROD_W + 2;   // 2*(a+b) and 1-2*(a+b)
    localparam int COORD_W = TERM_W + 2;   // cordic x/y with gain headroom
    localparam int ANGLE_W = 34;           // angle accumulator, q.30 radians
    localparam int MAG_W   = 30;           // |t2| below one
    localparam int SQ_W    = 2 * MAG_W;
    localparam int RAD_W   = 62;           // radicand, even width
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int RND_W   = ANGLE_W + 1 - 17;
    localparam int OUT_W   = 16;
    localparam int PITCH_W = 15;
    localparam int OUT_TDATA_W = 48;

    localparam logic signed [TERM_W-1:0]  ONE_Q30 = 34'sd1073741824;
    localparam logic signed [ANGLE_W-1:0] PI_Q30  = 34'sd3373259426;
    localparam logic [RAD_W-1:0]          RAD_ONE = RAD_W'(1) << 60;
    localparam logic signed [RND_W-1:0]   ROLL_LIM  = 18'sd25736;
    localparam logic signed [RND_W-1:0]   PITCH_LIM = 18'sd12868;

    typedef logic signed [QW-1:0]      t_comp;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ANGLE_W-1:0] t_angle;

    // terms that ride alongside the square root
    typedef struct packed {
        t_term t0;
        t_term t1;
        t_term t2;
        t_term t3;
        t_term t4;
        logic  clamped;
        logic  t2_pos;
    } t_sq_side;

    // pitch saturation flags that ride alongside the cordic
    typedef struct packed {
        logic clamped;
        logic t2_pos;
    } t_pitch_flags;

    // atan(2^-i) in q.30, truncated
    function automatic t_angle atan_q30(input int unsigned idx);
        t_angle v;
        case (idx)
            0:  v = 34'sh3243F6A8;
            1:  v = 34'sh1DAC6705;
            2:  v = 34'sh0FADBAFC;
            3:  v = 34'sh07F56EA6;
            4:  v = 34'sh03FEAB76;
            5:  v = 34'sh01FFD55B;
            6:  v = 34'sh00FFFAAA;
            7:  v = 34'sh007FFF55;
            8:  v = 34'sh003FFFEA;
            9:  v = 34'sh001FFFFD;
            10: v = 34'sh000FFFFF;
            11: v = 34'sh0007FFFF;
            12: v = 34'sh0003FFFF;
            13: v = 34'sh0001FFFF;
            14: v = 34'sh0000FFFF;
            15: v = 34'sh00007FFF;
            16: v = 34'sh00003FFF;
            17: v = 34'sh00001FFF;
            18: v = 34'sh00000FFF;
            19: v = 34'sh000007FF;
            20: v = 34'sh000003FF;
            21: v = 34'sh000001FF;
            22: v = 34'sh000000FF;
            23: v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // q.30 to q5.13, round half up
    function automatic logic signed [RND_W-1:0] q13_round(input t_angle a);
        logic signed [ANGLE_W:0] s;
        s = (ANGLE_W+1)'(a) + (ANGLE_W+1)'(65536);
        return RND_W'(s >>> 17);
    endfunction

    function automatic logic signed [RND_W-1:0] q13_sat(
        input logic signed [RND_W-1:0] v,
        input logic signed [RND_W-1:0] lim
    );
        logic signed [RND_W-1:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end
        if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/q2e_isqrt.sv =====
// q2e_isqrt: pipelined floor integer square root, one result bit per stage
// depends on q2e_pkg
`default_nettype none

module q2e_isqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [q2e_pkg::RAD_W-1:0]      i_rad,
    input  wire logic [SIDE_W-1:0]              i_side,
    output logic                                o_valid,
    output logic [q2e_pkg::ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]                   o_side
);

    localparam int RW  = q2e_pkg::RAD_W;
    localparam int TW  = q2e_pkg::ROOT_W;
    localparam int MW  = q2e_pkg::REM_W;

    logic [RW-1:0]     r_rad   [TW+1];
    logic [MW-1:0]     r_rem   [TW+1];
    logic [TW-1:0]     r_root  [TW+1];
    logic [SIDE_W-1:0] r_side  [TW+1];
    logic              r_valid [TW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= TW; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 0; s < TW; s++) begin
                r_valid[s+1] <= r_valid[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < TW; j++) begin : g_digit
        logic [MW-1:0] w_rem_sh;
        logic [MW-1:0] w_trial;
        logic          w_ge;

        assign w_rem_sh = {r_rem[j][MW-3:0], r_rad[j][RW-1:RW-2]};
        assign w_trial  = {r_root[j], 2'b01};
        assign w_ge     = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j+1]  <= r_rad[j] << 2;
                r_rem[j+1]  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root[j+1] <= {r_root[j][TW-2:0], w_ge};
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_valid[TW];
    assign o_root  = r_root[TW];
    assign o_side  = r_side[TW];

endmodule

`default_nettype wire

// ===== rtl/core/q2e_cordic.sv =====
// q2e_cordic: pipelined vectoring cordic atan2, several lanes in lockstep
// depends on q2e_pkg
`default_nettype none

module q2e_cordic #(
    parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire q2e_pkg::t_coord       i_y [LANES],
    input  wire q2e_pkg::t_coord       i_x [LANES],
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output q2e_pkg::t_angle            o_angle [LANES],
    output logic [SIDE_W-1:0]          o_side
);

    localparam int MSB = q2e_pkg::COORD_W - 1;

    q2e_pkg::t_coord r_x    [STAGES+1][LANES];
    q2e_pkg::t_coord r_y    [STAGES+1][LANES];
    q2e_pkg::t_angle r_z    [STAGES+1][LANES];
    logic            r_zero [STAGES+1][LANES];
    logic [SIDE_W-1:0] r_side [STAGES+1];
    logic            r_valid [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 0; s < STAGES; s++) begin
                r_valid[s+1] <= r_valid[s];
            end
        end
    end

    // pre-rotation by pi for a negative abscissa
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_zero[0][l] <= (i_x[l] == '0) && (i_y[l] == '0);
                if (i_x[l][MSB]) begin
                    r_x[0][l] <= -i_x[l];
                    r_y[0][l] <= -i_y[l];
                    r_z[0][l] <= i_y[l][MSB] ? -q2e_pkg::PI_Q30 : q2e_pkg::PI_Q30;
                end else begin
                    r_x[0][l] <= i_x[l];
                    r_y[0][l] <= i_y[l];
                    r_z[0][l] <= '0;
                end
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                for (int l = 0; l < LANES; l++) begin
                    r_zero[k+1][l] <= r_zero[k][l];
                    if (!r_y[k][l][MSB]) begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + q2e_pkg::atan_q30(k);
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - q2e_pkg::atan_q30(k);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_angle[l] = r_zero[STAGES][l] ? '0 : r_z[STAGES][l];
        end
    end

    assign o_valid = r_valid[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_to_euler_unit.sv =====
// quaternion_to_euler_unit: quaternion (q1.15) to roll, pitch, yaw (q3.13 radians)
// depends on q2e_pkg, q2e_isqrt, q2e_cordic
//
// input stream: one beat per quaternion, tdata holds x, y, z, w, each
//   COMPONENT_BITS wide, x in the lowest bits
// output stream: one beat per quaternion, tdata holds roll (16), pitch (15),
//   yaw (16) from bit 0 up, tuser[0] flags a saturated pitch
// path from input beat to output beat: registers for the components, the products,
//   the terms and t2 squared, then the bit-per-stage square root of 1 - t2^2, the
//   pre-rotation and CORDIC_STAGES iterations of the three cordic lanes that run
//   side by side, and rounding into the output register
// throughput: one beat per cycle unless the output stalls, every stage is a register with a valid bit
// stall: when the output register holds a beat that is not taken, the whole
//   pipeline freezes and s_axis tready drops; nothing is lost or repeated
// reset: synchronous, clears every valid bit; data registers are not reset
`default_nettype none

module quaternion_to_euler_unit #(
    parameter int CORDIC_STAGES  = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int COMPONENT_BITS = q2e_pkg::COMPONENT_BITS_DEF,
    localparam int IN_TDATA_W    = ((4 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]            i_s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
    // master side
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [q2e_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic [0:0]                            o_m_axis_tuser   // pitch_clamped
);

    localparam int CB  = COMPONENT_BITS;
    localparam int QW  = q2e_pkg::QW;
    localparam int TW  = q2e_pkg::TERM_W;
    localparam int MAG = q2e_pkg::MAG_W;
    localparam int SQ_SIDE_W = $bits(q2e_pkg::t_sq_side);
    localparam int PF_W      = $bits(q2e_pkg::t_pitch_flags);

    // one global advance: the pipeline moves unless the output beat is stuck
    logic w_en;
    logic r_out_valid;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // bring each component to q1.15: floor for wider, zero fill for narrower
    q2e_pkg::t_comp w_norm [4];

    for (genvar g = 0; g < 4; g++) begin : g_norm
        logic [CB-1:0] w_raw;
        assign w_raw = i_s_axis_tdata[g*CB +: CB];
        if (CB > QW) begin : g_wide
            assign w_norm[g] = w_raw[CB-1 -: QW];
        end else if (CB < QW) begin : g_narrow
            assign w_norm[g] = {w_raw, {(QW-CB){1'b0}}};
        end else begin : g_same
            assign w_norm[g] = w_raw;
        end
    end

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: components (0 = x, 1 = y, 2 = z, 3 = w)
    q2e_pkg::t_comp r_q [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int g = 0; g < 4; g++) begin
                r_q[g] <= w_norm[g];
            end
        end
    end

    // stage 2: the nine products
    q2e_pkg::t_prod r_p_wx, r_p_yz, r_p_wy, r_p_zx, r_p_wz, r_p_xy;
    q2e_pkg::t_prod r_p_xx, r_p_yy, r_p_zz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_wx <= r_q[3] * r_q[0];
            r_p_yz <= r_q[1] * r_q[2];
            r_p_wy <= r_q[3] * r_q[1];
            r_p_zx <= r_q[2] * r_q[0];
            r_p_wz <= r_q[3] * r_q[2];
            r_p_xy <= r_q[0] * r_q[1];
            r_p_xx <= r_q[0] * r_q[0];
            r_p_yy <= r_q[1] * r_q[1];
            r_p_zz <= r_q[2] * r_q[2];
        end
    end

    // stage 3: the five terms in q.30
    q2e_pkg::t_term r_t0, r_t1, r_t2, r_t3, r_t4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0 <= (TW'(r_p_wx) + TW'(r_p_yz)) <<< 1;
            r_t1 <= q2e_pkg::ONE_Q30 - ((TW'(r_p_xx) + TW'(r_p_yy)) <<< 1);
            r_t2 <= (TW'(r_p_wy) - TW'(r_p_zx)) <<< 1;
            r_t3 <= (TW'(r_p_wz) + TW'(r_p_xy)) <<< 1;
            r_t4 <= q2e_pkg::ONE_Q30 - ((TW'(r_p_yy) + TW'(r_p_zz)) <<< 1);
        end
    end

    // stage 4: t2 squared and the saturation test
    q2e_pkg::t_term             w_t2_abs;
    logic [q2e_pkg::SQ_W-1:0]   r_sq;
    q2e_pkg::t_sq_side          r_s4;

    assign w_t2_abs = r_t2[TW-1] ? -r_t2 : r_t2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq         <= w_t2_abs[MAG-1:0] * w_t2_abs[MAG-1:0];
            r_s4.t0      <= r_t0;
            r_s4.t1      <= r_t1;
            r_s4.t2      <= r_t2;
            r_s4.t3      <= r_t3;
            r_s4.t4      <= r_t4;
            r_s4.clamped <= (r_t2 >= q2e_pkg::ONE_Q30) || (r_t2 <= -q2e_pkg::ONE_Q30);
            r_s4.t2_pos  <= !r_t2[TW-1] && (r_t2 != '0);
        end
    end

    // cos of pitch: floor sqrt(1 - t2^2) in q.30
    logic [q2e_pkg::RAD_W-1:0]  w_rad;
    logic                       w_sq_valid;
    logic [q2e_pkg::ROOT_W-1:0] w_root;
    logic [SQ_SIDE_W-1:0]       w_sq_side_bits;
    q2e_pkg::t_sq_side          w_sq_side;

    assign w_rad     = q2e_pkg::RAD_ONE - q2e_pkg::RAD_W'(r_sq);
    assign w_sq_side = q2e_pkg::t_sq_side'(w_sq_side_bits);

    q2e_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_rad   (w_rad),
        .i_side  (SQ_SIDE_W'(r_s4)),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side_bits)
    );

    // three atan2 lanes: roll, pitch, yaw
    q2e_pkg::t_coord       w_cy [3];
    q2e_pkg::t_coord       w_cx [3];
    q2e_pkg::t_angle       w_ang [3];
    q2e_pkg::t_pitch_flags w_pf_in;
    q2e_pkg::t_pitch_flags w_pf_out;
    logic [PF_W-1:0]       w_pf_bits;
    logic                  w_cor_valid;

    assign w_cy[0] = q2e_pkg::COORD_W'(w_sq_side.t0);
    assign w_cx[0] = q2e_pkg::COORD_W'(w_sq_side.t1);
    assign w_cy[1] = q2e_pkg::COORD_W'(w_sq_side.t2);
    assign w_cx[1] = q2e_pkg::COORD_W'(w_root);
    assign w_cy[2] = q2e_pkg::COORD_W'(w_sq_side.t3);
    assign w_cx[2] = q2e_pkg::COORD_W'(w_sq_side.t4);

    assign w_pf_in.clamped = w_sq_side.clamped;
    assign w_pf_in.t2_pos  = w_sq_side.t2_pos;
    assign w_pf_out        = q2e_pkg::t_pitch_flags'(w_pf_bits);

    q2e_cordic #(
        .STAGES (CORDIC_STAGES),
        .LANES  (3),
        .SIDE_W (PF_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_y     (w_cy),
        .i_x     (w_cx),
        .i_side  (PF_W'(w_pf_in)),
        .o_valid (w_cor_valid),
        .o_angle (w_ang),
        .o_side  (w_pf_bits)
    );

    // rounding, saturation and the pitch clamp
    logic signed [q2e_pkg::RND_W-1:0] w_roll, w_pitch, w_yaw;

    always_comb begin
        w_roll  = q2e_pkg::q13_sat(q2e_pkg::q13_round(w_ang[0]), q2e_pkg::ROLL_LIM);
        w_yaw   = q2e_pkg::q13_sat(q2e_pkg::q13_round(w_ang[2]), q2e_pkg::ROLL_LIM);
        if (w_pf_out.clamped) begin
            w_pitch = w_pf_out.t2_pos ? q2e_pkg::PITCH_LIM : -q2e_pkg::PITCH_LIM;
        end else begin
            w_pitch = q2e_pkg::q13_sat(q2e_pkg::q13_round(w_ang[1]), q2e_pkg::PITCH_LIM);
        end
    end

    // output register
    logic signed [q2e_pkg::OUT_W-1:0]   r_roll, r_yaw;
    logic signed [q2e_pkg::PITCH_W-1:0] r_pitch;
    logic                               r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cor_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll    <= q2e_pkg::OUT_W'(w_roll);
            r_pitch   <= q2e_pkg::PITCH_W'(w_pitch);
            r_yaw     <= q2e_pkg::OUT_W'(w_yaw);
            r_clamped <= w_pf_out.clamped;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {1'b0, r_yaw, r_pitch, r_roll};
    assign o_m_axis_tuser[0] = r_clamped;

endmodule

`default_nettype wire

// ===== rtl/core/q2e_checker.sv =====
// q2e_checker: port-level assertions for quaternion_to_euler_unit, bound to the top level
// depends on q2e_pkg
`default_nettype none

module q2e_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_axis_tready,
    input wire logic                           i_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [q2e_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    input wire logic [0:0]                     i_m_axis_tuser
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("output beat changed while stalled");

    // with an empty output register the input side never pushes back
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_axis_tvalid |-> i_s_axis_tready)
        else $error("input stalled with empty output");

    // a clamped pitch sits exactly at plus or minus pi/2
    a_clamp_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser[0] |->
            ($signed(i_m_axis_tdata[30:16]) == 15'sd12868) ||
            ($signed(i_m_axis_tdata[30:16]) == -15'sd12868))
        else $error("clamped pitch not at pi/2");

    // roll and yaw stay within plus or minus pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |->
            ($signed(i_m_axis_tdata[15:0]) <= 16'sd25736) &&
            ($signed(i_m_axis_tdata[15:0]) >= -16'sd25736) &&
            ($signed(i_m_axis_tdata[46:31]) <= 16'sd25736) &&
            ($signed(i_m_axis_tdata[46:31]) >= -16'sd25736))
        else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_unit q2e_checker u_q2e_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for quaternion_to_euler_unit: directed, random and backpressure tests
// predicts roll, pitch and yaw with a behavioral cordic and checks each output beat
// depends on q2e_pkg and quaternion_to_euler_unit
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_quat;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_euler;

    localparam int  STAGES     = q2e_pkg::CORDIC_STAGES_DEF;
    localparam int  LATENCY    = 38 + STAGES;
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint ANGLE_LIM = 25736;
    localparam longint HALF_PI_LIM = 12868;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // roll_angle, pitch_angle, yaw_angle
    logic [0:0]  o_m_axis_tuser;   // pitch_clamped

    quaternion_to_euler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_euler angles_pending[$];
    int     mismatch_cnt;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;   // long receiver stall requested by a test

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // atan(2^-i) in q.30, truncated
    function automatic longint atan_step(input int i);
        longint tbl[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tbl[i];
    endfunction

    // vectoring cordic, angle in q.30
    function automatic longint vector_angle(input longint ord, input longint absc);
        longint acc;
        longint xs;
        longint ys;
        acc = 0;
        if (ord == 0 && absc == 0) begin
            return 0;
        end
        // left half plane: rotate by pi first
        if (absc < 0) begin
            acc  = (ord >= 0) ? PI_Q30 : -PI_Q30;
            absc = -absc;
            ord  = -ord;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = absc >>> i;
            ys = ord >>> i;
            if (ord >= 0) begin
                absc = absc + ys;
                ord  = ord - xs;
                acc  = acc + atan_step(i);
            end else begin
                absc = absc - ys;
                ord  = ord + xs;
                acc  = acc - atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint round_q13(input longint a, input longint lim);
        longint r;
        r = (a + 65536) >>> 17;
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_euler quat_to_euler(input t_quat q);
        t_euler e;
        longint x;
        longint y;
        longint z;
        longint w;
        longint t0;
        longint t1;
        longint t2;
        longint t3;
        longint t4;
        longint unsigned root;
        x  = q.x;
        y  = q.y;
        z  = q.z;
        w  = q.w;
        t0 = 2 * (w * x + y * z);
        t1 = UNIT_Q30 - 2 * (x * x + y * y);
        t2 = 2 * (w * y - z * x);
        t3 = 2 * (w * z + x * y);
        t4 = UNIT_Q30 - 2 * (y * y + z * z);
        e.roll = 16'(round_q13(vector_angle(t0, t1), ANGLE_LIM));
        e.yaw  = 16'(round_q13(vector_angle(t3, t4), ANGLE_LIM));
        // pitch term at or beyond unit magnitude saturates to +-pi/2
        if (t2 >= UNIT_Q30 || t2 <= -UNIT_Q30) begin
            e.pitch   = (t2 > 0) ? 15'(HALF_PI_LIM) : 15'(-HALF_PI_LIM);
            e.clamped = 1'b1;
        end else begin
            root      = floor_sqrt((64'd1 << 60) - longint'(t2 * t2));
            e.pitch   = 15'(round_q13(vector_angle(t2, longint'(root)), HALF_PI_LIM));
            e.clamped = 1'b0;
        end
        return e;
    endfunction

    // one quaternion beat; expectation queued when the beat is taken
    task automatic send_quat(input t_quat q);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= q;
        // inputs only move at the rising edge, so the falling edge sees them settled
        forever begin
            @(negedge i_clk);
            if (o_s_axis_tready) begin
                break;
            end
            @(posedge i_clk);
        end
        angles_pending.push_back(quat_to_euler(q));
        @(posedge i_clk);
    endtask

    function automatic t_quat rand_quat(input bit scaled);
        t_quat q;
        q = {$urandom, $urandom};
        // scaled components keep most pitch terms below saturation
        if (scaled) begin
            q.x = q.x >>> 1;
            q.y = q.y >>> 1;
            q.z = q.z >>> 1;
            q.w = q.w >>> 1;
        end
        return q;
    endfunction

    // receiver: random stalls, plus a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (recv_stall_pct > 0) begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // output beat check, sampled on the falling edge before it is taken
    always @(negedge i_clk) begin
        t_euler exp_a;
        t_euler got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.roll    = o_m_axis_tdata[15:0];
            got.pitch   = o_m_axis_tdata[30:16];
            got.yaw     = o_m_axis_tdata[46:31];
            got.clamped = o_m_axis_tuser[0];
            if (angles_pending.size() == 0) begin
                $display("%0t: unexpected beat roll=%0d pitch=%0d yaw=%0d clamped=%0b",
                         $time, got.roll, got.pitch, got.yaw, got.clamped);
                mismatch_cnt++;
            end else begin
                exp_a = angles_pending.pop_front();
                if (got.roll !== exp_a.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, got.roll);
                    mismatch_cnt++;
                end
                if (got.pitch !== exp_a.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d",
                             $time, exp_a.pitch, got.pitch);
                    mismatch_cnt++;
                end
                if (got.yaw !== exp_a.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw, got.yaw);
                    mismatch_cnt++;
                end
                if (got.clamped !== exp_a.clamped) begin
                    $display("%0t: clamped expected %0b actual %0b",
                             $time, exp_a.clamped, got.clamped);
                    mismatch_cnt++;
                end
            end
        end
    end

    // extremes and the named corner cases
    task automatic test_corner_quats();
        t_quat list[$];
        list.push_back('{w: 16'sd0,      z: 16'sd0,      y: 16'sd0,      x: 16'sd0});
        list.push_back('{w: 16'sd32767,  z: 16'sd0,      y: 16'sd0,      x: 16'sd0});
        list.push_back('{w: -16'sd32768, z: -16'sd32768, y: -16'sd32768, x: -16'sd32768});
        list.push_back('{w: 16'sd32767,  z: 16'sd32767,  y: 16'sd32767,  x: 16'sd32767});
        // zero vector for roll: t0 = 0 and t1 = 0
        list.push_back('{w: 16'sd0,      z: 16'sd0,      y: 16'sd16384,  x: 16'sd16384});
        // negative abscissa, ordinate zero, negative and positive
        list.push_back('{w: 16'sd0,      z: 16'sd0,      y: 16'sd0,      x: 16'sd32767});
        list.push_back('{w: -16'sd3000,  z: 16'sd0,      y: 16'sd0,      x: 16'sd32767});
        list.push_back('{w: 16'sd3000,   z: 16'sd32767,  y: 16'sd0,      x: 16'sd0});
        // pitch saturation, both signs, and exactly minus one
        list.push_back('{w: 16'sd32767,  z: 16'sd0,      y: 16'sd32767,  x: 16'sd0});
        list.push_back('{w: 16'sd32767,  z: 16'sd0,      y: -16'sd32767, x: 16'sd0});
        list.push_back('{w: -16'sd32768, z: 16'sd0,      y: 16'sd16384,  x: 16'sd0});
        // pitch just below saturation, then two with a zero pitch term
        list.push_back('{w: 16'sd23170,  z: 16'sd0,      y: 16'sd23170,  x: 16'sd0});
        list.push_back('{w: 16'sd23170,  z: 16'sd0,      y: -16'sd23170, x: 16'sd0});
        list.push_back('{w: 16'sd16384,  z: 16'sd16384,  y: 16'sd16384,  x: 16'sd16384});
        list.push_back('{w: 16'sd1,      z: -16'sd1,     y: 16'sd1,      x: -16'sd1});
        foreach (list[i]) begin
            send_quat(list[i]);
        end
    endtask

    task automatic test_random_stream(input int count, input int idle_pct,
                                      input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            send_quat(rand_quat($urandom_range(1)));
        end
    endtask

    // receiver holds off long enough that the pipeline fills and input stalls
    task automatic test_output_hold_off();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 4 * LATENCY;
        repeat (2 * LATENCY) begin
            send_quat(rand_quat(1'b1));
        end
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        i_s_axis_tvalid <= 1'b0;
        while (angles_pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        mismatch_cnt    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_quats();
        test_output_hold_off();
        test_random_stream(390, 35, 86);
        test_random_stream(390, 86, 35);
        test_random_stream(390, 0, 0);
        drain_results();

        if (mismatch_cnt == 0 && angles_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #500000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/q2e_pkg.sv
rtl/core/q2e_isqrt.sv
rtl/core/q2e_cordic.sv
rtl/core/quaternion_to_euler_unit.sv
rtl/core/q2e_checker.sv
tb/testbench.sv
